// ----- sv/cbm_pkg.sv -----
// cbm_pkg: shared types and constants for the cartridge bank mapper.
// Used by cartridge_bank_mapper; no dependencies.
`default_nettype none

package cbm_pkg;

    localparam int RAM_BANKS      = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_OFS_W      = 13;
    localparam int ROM_OFS_W      = 14;
    localparam int ROM_BANK_W     = 8;
    localparam int OFFSET_W       = 22;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2
    } target_t;

    // address regions by the top three address bits
    localparam logic [2:0] RGN_RAM_EN   = 3'b000;
    localparam logic [2:0] RGN_ROM_LOW  = 3'b001;
    localparam logic [2:0] RGN_RAM_BANK = 3'b010;
    localparam logic [2:0] RGN_ROM_HIGH = 3'b011;
    localparam logic [2:0] RGN_EXT_RAM  = 3'b101;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [6:0] ROM_LOW_MASK = 7'h7F;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          target;
        logic [OFFSET_W-1:0] rom_offset;
        logic [7:0]          read_data;
        logic                handled;
        logic                ram_enabled;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/cbm_ram.sv -----
// cbm_ram: generic single-port RAM with registered read and enable.
// No dependencies.
`default_nettype none

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/cartridge_bank_mapper.sv -----
// cartridge_bank_mapper: cartridge bank controller, top level.
// Depends on cbm_pkg and cbm_ram.
//
// Usage:
//   s_valid/s_ready/s_item carry one bus access (action, address, write byte).
//   m_valid/m_ready/m_item carry one result item per access: read target,
//   ROM offset, RAM byte, handled flag and the RAM enable flag.
//   cfg_wr_en/cfg_wr_data write the upper ROM bank bits.
//   Throughput: one item per cycle while m_ready stays high and no clearing
//   pass runs. The external RAM is a single-port memory, touched once per
//   external RAM item (read or write) at the accept edge. An accepted item
//   passes the RAM read stage, then the output register, which drives
//   m_valid.
//   Reset: bank registers return to their defaults, then a clearing pass
//   writes zero to every RAM byte; s_ready stays low during that pass.
//   Config writes are taken.
//   Stall: the output register and the RAM stage hold one item each, so
//   one more item is accepted while m_ready is low; then s_ready drops.
`default_nettype none

module cartridge_bank_mapper #(
    parameter int RAM_BANKS = cbm_pkg::RAM_BANKS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cbm_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cbm_pkg::out_item_t     m_item,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data
);

    localparam int RAM_DEPTH = RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RAM_DEPTH - 1);
    localparam logic [2:0] BANKS_W3 = 3'(RAM_BANKS);
    localparam logic [1:0] BANKS_W2 = 2'(RAM_BANKS);

    logic [1:0] rom_bank_high_reg;
    logic [6:0] rom_bank_low_reg, rom_bank_low_next;
    logic [1:0] ram_bank_sel_reg, ram_bank_sel_next;
    logic       ram_en_reg, ram_en_next;

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic                          s1_valid_reg;
    cbm_pkg::target_t              s1_target_reg, s1_target_next;
    logic [cbm_pkg::OFFSET_W-1:0]  s1_offset_reg, s1_offset_next;
    logic                          s1_handled_reg, s1_handled_next;
    logic                          s1_enabled_reg;

    logic               out_valid_reg;
    cbm_pkg::out_item_t out_item_reg;

    logic accept, advance;
    logic [2:0] region;
    logic [1:0] bank;
    logic [cbm_pkg::RAM_OFS_W+1:0] ram_idx;
    logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank;
    logic              ram_en_p, ram_we_p;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    assign advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign accept  = s_valid && s_ready;
    assign region  = s_item.address[15:13];

    always_comb begin
        bank = ram_bank_sel_reg;
        for (int i = 0; i < 3; i++) begin
            if ({1'b0, bank} >= BANKS_W3) begin
                bank = bank - BANKS_W2;
            end
        end
    end

    assign ram_idx  = {bank, s_item.address[cbm_pkg::RAM_OFS_W-1:0]};
    assign rom_bank = {1'b0, rom_bank_high_reg, 5'd0} + {1'b0, rom_bank_low_reg};

    always_comb begin
        rom_bank_low_next = rom_bank_low_reg;
        ram_bank_sel_next = ram_bank_sel_reg;
        ram_en_next       = ram_en_reg;
        s1_target_next    = cbm_pkg::TGT_NONE;
        s1_offset_next    = '0;
        s1_handled_next   = 1'b0;
        if (s_item.action == cbm_pkg::ACT_WRITE) begin
            unique case (region)
                cbm_pkg::RGN_RAM_EN: begin
                    ram_en_next     = (s_item.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                    s1_handled_next = 1'b1;
                end
                cbm_pkg::RGN_ROM_LOW: begin
                    rom_bank_low_next = (s_item.write_data == 8'd0) ? 7'd1 :
                                        (s_item.write_data[6:0] & cbm_pkg::ROM_LOW_MASK);
                    s1_handled_next   = 1'b1;
                end
                cbm_pkg::RGN_RAM_BANK: begin
                    if (s_item.write_data[7:2] == 6'd0) begin
                        ram_bank_sel_next = s_item.write_data[1:0];
                    end
                    s1_handled_next = 1'b1;
                end
                cbm_pkg::RGN_EXT_RAM: begin
                    s1_handled_next = 1'b1;
                end
                default: begin
                    s1_handled_next = 1'b0;
                end
            endcase
        end else begin
            unique case (region) inside
                cbm_pkg::RGN_RAM_EN, cbm_pkg::RGN_ROM_LOW: begin
                    s1_target_next = cbm_pkg::TGT_ROM;
                    s1_offset_next = {6'd0, s_item.address};
                end
                cbm_pkg::RGN_RAM_BANK, cbm_pkg::RGN_ROM_HIGH: begin
                    s1_target_next = cbm_pkg::TGT_ROM;
                    s1_offset_next = {rom_bank, s_item.address[cbm_pkg::ROM_OFS_W-1:0]};
                end
                cbm_pkg::RGN_EXT_RAM: begin
                    s1_target_next = cbm_pkg::TGT_RAM;
                end
                default: begin
                    s1_target_next = cbm_pkg::TGT_NONE;
                end
            endcase
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            ram_en_p  = 1'b1;
            ram_we_p  = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = 8'd0;
        end else begin
            ram_en_p  = accept && (region == cbm_pkg::RGN_EXT_RAM);
            ram_we_p  = (s_item.action == cbm_pkg::ACT_WRITE);
            ram_addr  = ram_idx[ADDR_W-1:0];
            ram_wdata = s_item.write_data;
        end
    end

    cbm_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ext_ram (
        .aclk (aclk),
        .en   (ram_en_p),
        .we   (ram_we_p),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_high_reg <= 2'd0;
            rom_bank_low_reg  <= 7'd1;
            ram_bank_sel_reg  <= 2'd0;
            ram_en_reg        <= 1'b0;
            clr_busy_reg      <= 1'b1;
            clr_addr_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rom_bank_high_reg <= cfg_wr_data;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept) begin
                rom_bank_low_reg <= rom_bank_low_next;
                ram_bank_sel_reg <= ram_bank_sel_next;
                ram_en_reg       <= ram_en_next;
                s1_valid_reg     <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_target_reg  <= s1_target_next;
            s1_offset_reg  <= s1_offset_next;
            s1_handled_reg <= s1_handled_next;
            s1_enabled_reg <= ram_en_next;
        end
        if (advance) begin
            out_item_reg.target      <= s1_target_reg;
            out_item_reg.rom_offset  <= s1_offset_reg;
            out_item_reg.read_data   <= (s1_target_reg == cbm_pkg::TGT_RAM) ? ram_rdata : 8'd0;
            out_item_reg.handled     <= s1_handled_reg;
            out_item_reg.ram_enabled <= s1_enabled_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

`default_nettype wire

// ----- test/tb_cartridge_bank_mapper.sv -----
// tb_cartridge_bank_mapper: self-checking testbench for the cartridge bank mapper.
// Predicts every result item from its own copy of the bank registers and external
// RAM; depends on cbm_pkg and cartridge_bank_mapper.
module tb_cartridge_bank_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RAM_BYTES      = cbm_pkg::RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    cbm_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    cbm_pkg::out_item_t m_item;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_data;

    // mapper state as the testbench sees it
    logic [1:0] rom_bank_hi;
    logic [6:0] rom_bank_lo;
    logic [1:0] ram_bank_sel;
    logic       ram_en;
    logic [7:0] ext_ram_image [0:RAM_BYTES-1];

    cbm_pkg::out_item_t pending_results[$];
    int        errors      = 0;
    int        items_sent  = 0;
    int        idle_cycles = 0;
    int        gap_pct     = 25;
    bit        quiet_tail  = 1'b0;

    cartridge_bank_mapper u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void reset_mapper_state();
        rom_bank_hi  = 2'd0;
        rom_bank_lo  = 7'd1;
        ram_bank_sel = 2'd0;
        ram_en       = 1'b0;
        for (int i = 0; i < RAM_BYTES; i++) begin
            ext_ram_image[i] = 8'h00;
        end
    endfunction

    // applies one bus access to the state and returns the result item it produces
    function automatic cbm_pkg::out_item_t map_access(cbm_pkg::in_item_t acc);
        cbm_pkg::out_item_t res;
        logic [2:0]         rgn;
        int                 ram_idx;
        logic [7:0]         bank;
        res     = '0;
        rgn     = acc.address[15:13];
        ram_idx = (int'(ram_bank_sel) % cbm_pkg::RAM_BANKS) * cbm_pkg::RAM_BANK_BYTES
                  + int'(acc.address[12:0]);
        if (acc.action == cbm_pkg::ACT_WRITE) begin
            case (rgn)
                cbm_pkg::RGN_RAM_EN: begin
                    ram_en = (acc.write_data[3:0] == cbm_pkg::RAM_EN_KEY);
                    res.handled = 1'b1;
                end
                cbm_pkg::RGN_ROM_LOW: begin
                    rom_bank_lo = (acc.write_data == 8'd0) ? 7'd1
                                  : acc.write_data[6:0] & cbm_pkg::ROM_LOW_MASK;
                    res.handled = 1'b1;
                end
                cbm_pkg::RGN_RAM_BANK: begin
                    if (acc.write_data[7:2] == 6'd0) begin
                        ram_bank_sel = acc.write_data[1:0];
                    end
                    res.handled = 1'b1;
                end
                cbm_pkg::RGN_EXT_RAM: begin
                    ext_ram_image[ram_idx] = acc.write_data;
                    res.handled = 1'b1;
                end
                default: ;
            endcase
        end else begin
            case (rgn) inside
                cbm_pkg::RGN_RAM_EN, cbm_pkg::RGN_ROM_LOW: begin
                    res.target     = cbm_pkg::TGT_ROM;
                    res.rom_offset = cbm_pkg::OFFSET_W'(acc.address);
                end
                cbm_pkg::RGN_RAM_BANK, cbm_pkg::RGN_ROM_HIGH: begin
                    bank           = {1'b0, rom_bank_hi, 5'b0} + {1'b0, rom_bank_lo};
                    res.target     = cbm_pkg::TGT_ROM;
                    res.rom_offset = {bank, acc.address[13:0]};
                end
                cbm_pkg::RGN_EXT_RAM: begin
                    res.target    = cbm_pkg::TGT_RAM;
                    res.read_data = ext_ram_image[ram_idx];
                end
                default: ;
            endcase
        end
        res.ram_enabled = ram_en;
        return res;
    endfunction

    function automatic cbm_pkg::in_item_t bus_op(logic act, logic [15:0] addr,
                                                 logic [7:0] data);
        cbm_pkg::in_item_t acc;
        acc.action     = act;
        acc.address    = addr;
        acc.write_data = data;
        return acc;
    endfunction

    // offsets cluster at both ends of a bank so writes and reads collide often
    function automatic logic [12:0] ram_offset();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            return 13'($urandom_range(0, 31));
        end else if (pick == 2) begin
            return 13'h1FE0 + 13'($urandom_range(0, 31));
        end
        return 13'($urandom);
    endfunction

    function automatic cbm_pkg::in_item_t random_access();
        cbm_pkg::in_item_t acc;
        int                pick;
        acc.action     = 1'($urandom_range(0, 1));
        acc.address    = 16'($urandom);
        acc.write_data = 8'($urandom);
        pick           = $urandom_range(0, 99);
        if (pick < 10) begin
            acc.action         = cbm_pkg::ACT_WRITE;
            acc.address[15:13] = cbm_pkg::RGN_RAM_EN;
            if ($urandom_range(0, 1) == 1) begin
                acc.write_data[3:0] = cbm_pkg::RAM_EN_KEY;
            end
        end else if (pick < 20) begin
            acc.action         = cbm_pkg::ACT_WRITE;
            acc.address[15:13] = cbm_pkg::RGN_ROM_LOW;
            if ($urandom_range(0, 3) == 0) begin
                acc.write_data = 8'd0;
            end
        end else if (pick < 30) begin
            acc.action         = cbm_pkg::ACT_WRITE;
            acc.address[15:13] = cbm_pkg::RGN_RAM_BANK;
            if ($urandom_range(0, 3) != 0) begin
                acc.write_data = 8'($urandom_range(0, cbm_pkg::RAM_BANKS - 1));
            end
        end else if (pick < 60) begin
            acc.address = {cbm_pkg::RGN_EXT_RAM, ram_offset()};
        end else if (pick < 80) begin
            acc.action      = cbm_pkg::ACT_READ;
            acc.address[15] = 1'b0;
        end
        return acc;
    endfunction

    task automatic send_access(cbm_pkg::in_item_t acc);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= acc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(map_access(acc));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_rom_high(logic [1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rom_bank_hi  = value;
    endtask

    task automatic test_directed_regions();
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h0000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h3FFF, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h4000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h7FFF, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h8000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'hBFFF, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'hFFFF, 8'hFF));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h0000, 8'h0A));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h1FFF, 8'hFA));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h1000, 8'hA0));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h2000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h4000, 8'hFF));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h3FFF, 8'hFF));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h7FFF, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h4000, 8'h03));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h5FFF, 8'h04));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'hA000, 8'hFF));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'hBFFF, 8'h5A));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'hA000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h4000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_READ,  16'hA000, 8'h00));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h6000, 8'h12));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h8000, 8'h34));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'h9FFF, 8'h56));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'hC000, 8'h78));
        send_access(bus_op(cbm_pkg::ACT_WRITE, 16'hFFFF, 8'hFF));
        wait_idle();
        set_rom_high(2'd3);
        send_access(bus_op(cbm_pkg::ACT_READ,  16'h7FFF, 8'h00));
        wait_idle();
    endtask

    // bank select, a few stores, then read-back, with an occasional random access before the read-back
    task automatic bank_burst();
        logic [12:0] offsets[$];
        int          n;
        send_access(bus_op(cbm_pkg::ACT_WRITE, {cbm_pkg::RGN_RAM_BANK, 13'($urandom)},
                           8'($urandom_range(0, cbm_pkg::RAM_BANKS - 1))));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            offsets.push_back(ram_offset());
            send_access(bus_op(cbm_pkg::ACT_WRITE, {cbm_pkg::RGN_EXT_RAM, offsets[i]},
                               8'($urandom)));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_access(random_access());
        end
        foreach (offsets[i]) begin
            send_access(bus_op(cbm_pkg::ACT_READ, {cbm_pkg::RGN_EXT_RAM, offsets[i]},
                               8'($urandom)));
        end
    endtask

    task automatic test_bank_traffic();
        int stop_at;
        for (int phase = 0; phase < 2; phase++) begin
            set_rom_high(phase == 0 ? 2'd1 : 2'd2);
            gap_pct = (phase == 0) ? 30 : 0;
            stop_at = items_sent + 450;
            while (items_sent < stop_at) bank_burst();
            wait_idle();
        end
    endtask

    task automatic test_mixed_random();
        int stop_at;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: set_rom_high(2'd3);
                1: set_rom_high(2'd0);
                default: begin
                    set_rom_high(2'd2);
                    quiet_tail = 1'b1;
                end
            endcase
            gap_pct = (phase == 0) ? 50 : 15;
            stop_at = items_sent + 300;
            while (items_sent < stop_at) send_access(random_access());
            wait_idle();
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cbm_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("target",      want.target,      m_item.target);
                check_field("rom_offset",  want.rom_offset,  m_item.rom_offset);
                check_field("read_data",   want.read_data,   m_item.read_data);
                check_field("handled",     want.handled,     m_item.handled);
                check_field("ram_enabled", want.ram_enabled, m_item.ram_enabled);
            end
        end
    end

    // result side backpressure
    initial begin
        forever begin
            if (quiet_tail || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    // covers the RAM clearing pass after reset with margin
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** cartridge_bank_mapper: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_item      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 2'd0;
        reset_mapper_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_rom_high(2'd0);
        test_directed_regions();
        test_bank_traffic();
        test_mixed_random();
        repeat (4) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("** cartridge_bank_mapper: PASSED **");
        end else begin
            $display("** cartridge_bank_mapper: FAILED **");
        end
        $finish;
    end

endmodule
